>>> sv/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Shared types, command codes and cell constants for the text console.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int CMD_W         = 2;
  localparam int CHAR_W        = 8;
  localparam int COLOR_W       = 8;
  localparam int CELL_W        = 16;
  localparam int CELL_ADDR_W   = 11;
  localparam int CURSOR_POS_W  = 11;

  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_PTR_W   = 1;
  localparam int QUEUE_CNT_W   = 2;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [CELL_W-1:0]  BLANK_WHITE      = 16'h0F20;
  localparam logic [CELL_W-1:0]  BLANK_RESET      = 16'h0720;
  localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h07;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t                kind;
    logic [CHAR_W-1:0]       ch;
    logic [CELL_ADDR_W-1:0]  addr;
  } op_t;

  typedef struct packed {
    logic init_busy;
    logic pop;
  } bk_ctl_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL_COPY,
    ST_SCROLL_FILL,
    ST_CLEAR,
    ST_FINISH
  } back_state_t;

endpackage

>>> sv/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/tcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console front end
// Accepts input words, classifies them into operations and queues them.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int CELLS = 2000
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tcw_pkg::CMD_W-1:0]         in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]        in_char_code,
  input  logic [tcw_pkg::CELL_ADDR_W-1:0]   in_cell_address,
  input  tcw_pkg::bk_ctl_t                  bk_ctl,
  output logic                              head_valid,
  output tcw_pkg::op_t                      head
);

  localparam int CMP_W = tcw_pkg::CELL_ADDR_W + 2;
  localparam logic [CMP_W-1:0] CELLS_C = CMP_W'(CELLS);

  tcw_pkg::op_t                          q_r [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QUEUE_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [tcw_pkg::QUEUE_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [tcw_pkg::QUEUE_CNT_W-1:0]       count_r, count_nxt;
  logic                                  full;
  logic                                  push;
  logic                                  addr_ok;
  tcw_pkg::op_t                          op_in;

  assign full     = (count_r == tcw_pkg::QUEUE_CNT_W'(tcw_pkg::QUEUE_DEPTH));
  assign in_stall = full || bk_ctl.init_busy;
  assign push     = in_valid && !in_stall;
  assign addr_ok  = ({2'b00, in_cell_address} < CELLS_C);

  always_comb begin
    op_in.ch   = in_char_code;
    op_in.addr = in_cell_address;
    unique case (in_command)
      tcw_pkg::CMD_PUT: begin
        if (in_char_code == tcw_pkg::CH_NEWLINE) begin
          op_in.kind = tcw_pkg::OP_NEWLINE;
        end else if (in_char_code == tcw_pkg::CH_BACKSPACE) begin
          op_in.kind = tcw_pkg::OP_BACKSPACE;
        end else begin
          op_in.kind = tcw_pkg::OP_PUT;
        end
      end
      tcw_pkg::CMD_CLEAR: begin
        op_in.kind = tcw_pkg::OP_CLEAR;
      end
      tcw_pkg::CMD_READ: begin
        op_in.kind = addr_ok ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
      end
      default: begin
        op_in.kind = tcw_pkg::OP_NOP;
      end
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (bk_ctl.pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !bk_ctl.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && bk_ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= op_in;
    end
  end

  assign head_valid = (count_r != '0);
  assign head       = q_r[rd_ptr_r];

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tcw_pkg::QUEUE_CNT_W'(tcw_pkg::QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    bk_ctl.pop |-> head_valid)
    else $error("back end popped an empty queue");
`endif

endmodule

>>> sv/tcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console back end
// Executes queued operations on the cell memory and the cursor and
// drives the output register.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [tcw_pkg::COLOR_W-1:0]        text_color,
  input  logic                               head_valid,
  input  tcw_pkg::op_t                       head,
  output tcw_pkg::bk_ctl_t                   bk_ctl,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tcw_pkg::CELL_W-1:0]         out_cell_value,
  output logic [tcw_pkg::CURSOR_POS_W-1:0]   out_cursor_position
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int PW    = $clog2(CELLS);

  localparam logic [CW-1:0] COL_LAST      = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST      = RW'(ROWS - 1);
  localparam logic [PW-1:0] POS_LAST_ROW  = PW'((ROWS - 1) * COLUMNS);
  localparam logic [PW-1:0] CELLS_LAST    = PW'(CELLS - 1);
  localparam logic [PW-1:0] COLUMNS_P     = PW'(COLUMNS);

  tcw_pkg::back_state_t              state_r, state_nxt;
  logic [PW-1:0]                     cnt_r, cnt_nxt;
  logic [RW-1:0]                     row_r, row_nxt;
  logic [CW-1:0]                     col_r, col_nxt;
  logic [PW-1:0]                     pos_r, pos_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [tcw_pkg::CELL_W-1:0]        out_cell_r, out_cell_nxt;
  logic [PW-1:0]                     out_pos_r, out_pos_nxt;

  logic                              out_free;
  logic                              emit;
  logic [tcw_pkg::CELL_W-1:0]        emit_cell;
  logic                              ram_we;
  logic [PW-1:0]                     ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]        ram_wdata;
  logic                              ram_re;
  logic [PW-1:0]                     ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]        ram_rdata;
  logic [PW+tcw_pkg::CELL_ADDR_W-1:0]  head_addr_ext;
  logic [PW+tcw_pkg::CURSOR_POS_W-1:0] out_pos_ext;

  assign out_free      = !out_valid_r || !out_stall;
  assign head_addr_ext = {{PW{1'b0}}, head.addr};
  assign out_pos_ext   = {{tcw_pkg::CURSOR_POS_W{1'b0}}, out_pos_r};

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cell_nxt  = out_cell_r;
    out_pos_nxt   = out_pos_r;
    emit          = 1'b0;
    emit_cell     = '0;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = tcw_pkg::BLANK_WHITE;
    ram_re        = 1'b0;
    ram_raddr     = cnt_r + COLUMNS_P;
    bk_ctl.init_busy = (state_r == tcw_pkg::ST_INIT);
    bk_ctl.pop       = 1'b0;

    unique case (state_r)
      tcw_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = tcw_pkg::BLANK_RESET;
        if (cnt_r == CELLS_LAST) begin
          cnt_nxt   = '0;
          state_nxt = tcw_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      tcw_pkg::ST_IDLE: begin
        if (head_valid && out_free) begin
          bk_ctl.pop = 1'b1;
          unique case (head.kind)
            tcw_pkg::OP_PUT: begin
              ram_we    = 1'b1;
              ram_waddr = pos_r;
              ram_wdata = {text_color, head.ch};
              if (col_r == COL_LAST) begin
                col_nxt = '0;
                if (row_r == ROW_LAST) begin
                  pos_nxt   = POS_LAST_ROW;
                  cnt_nxt   = '0;
                  state_nxt = tcw_pkg::ST_SCROLL_COPY;
                end else begin
                  row_nxt = row_r + 1'b1;
                  pos_nxt = pos_r + 1'b1;
                  emit    = 1'b1;
                end
              end else begin
                col_nxt = col_r + 1'b1;
                pos_nxt = pos_r + 1'b1;
                emit    = 1'b1;
              end
            end
            tcw_pkg::OP_NEWLINE: begin
              col_nxt = '0;
              if (row_r == ROW_LAST) begin
                pos_nxt   = POS_LAST_ROW;
                cnt_nxt   = '0;
                state_nxt = tcw_pkg::ST_SCROLL_COPY;
              end else begin
                row_nxt = row_r + 1'b1;
                pos_nxt = pos_r - PW'(col_r) + COLUMNS_P;
                emit    = 1'b1;
              end
            end
            tcw_pkg::OP_BACKSPACE: begin
              if (col_r != '0) begin
                col_nxt = col_r - 1'b1;
                pos_nxt = pos_r - 1'b1;
              end else if (row_r != '0) begin
                row_nxt = row_r - 1'b1;
                col_nxt = COL_LAST;
                pos_nxt = pos_r - 1'b1;
              end
              ram_we    = 1'b1;
              ram_waddr = pos_nxt;
              ram_wdata = {text_color, tcw_pkg::CH_SPACE};
              emit      = 1'b1;
            end
            tcw_pkg::OP_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              pos_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = tcw_pkg::ST_CLEAR;
            end
            tcw_pkg::OP_READ: begin
              ram_re    = 1'b1;
              ram_raddr = head_addr_ext[PW-1:0];
              state_nxt = tcw_pkg::ST_READ;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      tcw_pkg::ST_READ: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_cell = ram_rdata;
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end

      tcw_pkg::ST_SCROLL_COPY: begin
        ram_re    = (cnt_r != POS_LAST_ROW);
        ram_we    = (cnt_r != '0);
        ram_waddr = cnt_r - 1'b1;
        ram_wdata = ram_rdata;
        if (cnt_r == POS_LAST_ROW) begin
          state_nxt = tcw_pkg::ST_SCROLL_FILL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      tcw_pkg::ST_SCROLL_FILL, tcw_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (cnt_r == CELLS_LAST) begin
          cnt_nxt   = '0;
          state_nxt = tcw_pkg::ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      tcw_pkg::ST_FINISH: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_cell_nxt  = emit_cell;
      out_pos_nxt   = pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_INIT;
      cnt_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_cell_r <= out_cell_nxt;
    out_pos_r  <= out_pos_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_cell_value      = out_cell_r;
  assign out_cursor_position = out_pos_ext[tcw_pkg::CURSOR_POS_W-1:0];

`ifndef SYNTHESIS
  a_pos_matches: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pos_r) == int'(row_r) * COLUMNS + int'(col_r))
    else $error("linear cursor disagrees with row and column");

  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(col_r) < COLUMNS) && (int'(row_r) < ROWS))
    else $error("cursor outside the grid");

  a_read_issued: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_READ) && ($past(state_r) != tcw_pkg::ST_READ)
      |-> $past(ram_re))
    else $error("read state entered without a memory read");
`endif

endmodule

>>> sv/text_console_writer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell console with cursor, scrolling, clear and cell reads.
// ----------------------------------------------------------------------------
// Character, newline, backspace and unused commands: one result word per cycle
// while out_stall is low and no scroll runs, held in the output register; a read
// also passes the memory read port. Clear walks the cell memory one cell a cycle,
// a scroll copies rows up and blanks the last row; meanwhile the queue fills, then
// in_stall rises. After reset a clearing pass over every cell holds in_stall high.
module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_write_en,
  input  logic [tcw_pkg::COLOR_W-1:0]        cfg_text_color,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tcw_pkg::CMD_W-1:0]          in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]         in_char_code,
  input  logic [tcw_pkg::CELL_ADDR_W-1:0]    in_cell_address,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tcw_pkg::CELL_W-1:0]         out_cell_value,
  output logic [tcw_pkg::CURSOR_POS_W-1:0]   out_cursor_position
);

  logic [tcw_pkg::COLOR_W-1:0] text_color_r;
  tcw_pkg::bk_ctl_t            bk_ctl;
  logic                        head_valid;
  tcw_pkg::op_t                head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= tcw_pkg::TEXT_COLOR_RESET;
    end else if (cfg_write_en) begin
      text_color_r <= cfg_text_color;
    end
  end

  tcw_front #(
    .CELLS (COLUMNS * ROWS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_char_code    (in_char_code),
    .in_cell_address (in_cell_address),
    .bk_ctl          (bk_ctl),
    .head_valid      (head_valid),
    .head            (head)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .text_color          (text_color_r),
    .head_valid          (head_valid),
    .head                (head),
    .bk_ctl              (bk_ctl),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cell_value      (out_cell_value),
    .out_cursor_position (out_cursor_position)
  );

endmodule
